### design/cartesian_to_polar_relative_macros.svh
// Assertion macros used by the converter RTL (c2p_out).
// Needs signals named clk and rst_n in the module that expands them.
`ifndef CARTESIAN_TO_POLAR_RELATIVE_MACROS_SVH
`define CARTESIAN_TO_POLAR_RELATIVE_MACROS_SVH

// same-cycle implication, checked out of reset
`define C2P_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define C2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/c2p_pkg.sv
// Types, constants and the arctangent table of the relative polar converter.
// No dependencies.
package c2p_pkg;

  localparam int COORD_W    = 16;
  localparam int RAD_W      = COORD_W + 9;
  localparam int ANG_W      = 16;
  localparam int SQ_W       = 2 * COORD_W + 1;
  localparam int RAD_SHIFT  = 16;
  localparam int RADICAND_W = 2 * RAD_W;
  localparam int GUARD_W    = 16;
  localparam int CX_W       = COORD_W + GUARD_W + 4;
  localparam int TURN_W     = 32;
  localparam int Z_W        = TURN_W + 2;
  localparam int REM_W      = RAD_W + 3;
  localparam int NCELLS     = RAD_W;
  localparam int TAB_LEN    = 24;
  localparam int CFG_IDX_W  = 1;

  localparam logic [TURN_W-1:0] QUARTER_TURN  = 32'h4000_0000;
  localparam logic [TURN_W-1:0] HALF_TURN     = 32'h8000_0000;
  localparam logic [TURN_W-1:0] THREE_Q_TURN  = 32'hC000_0000;
  localparam logic [TURN_W-1:0] ROUND_HALF    = 32'h0000_8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_X = 1'b0,
    REG_REF_Y = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic               last_item;
  } in_word_t;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [ANG_W-1:0] angle;
    logic             at_origin;
    logic             last_out;
  } out_word_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero_x;
    logic zero_y;
    logic last;
  } flags_t;

  typedef struct packed {
    logic [CX_W-1:0]       cx;
    logic [CX_W-1:0]       cy;
    logic [Z_W-1:0]        cz;
    logic [RADICAND_W-1:0] rad;
    logic [REM_W-1:0]      rem;
    logic [RAD_W-1:0]      root;
    flags_t                f;
  } cell_t;

  // atan(2^-i) as a Q32 fraction of a full turn
  function automatic logic [TURN_W-1:0] atan_turn(input int idx);
    case (idx)
      0:       return 32'h2000_0000;
      1:       return 32'h12E4_051E;
      2:       return 32'h09FB_385B;
      3:       return 32'h0511_11D4;
      4:       return 32'h028B_0D43;
      5:       return 32'h0145_D7E1;
      6:       return 32'h00A2_F61E;
      7:       return 32'h0051_7C55;
      8:       return 32'h0028_BE53;
      9:       return 32'h0014_5F2F;
      10:      return 32'h000A_2F98;
      11:      return 32'h0005_17CC;
      12:      return 32'h0002_8BE6;
      13:      return 32'h0001_45F3;
      14:      return 32'h0000_A2F9;
      15:      return 32'h0000_517C;
      16:      return 32'h0000_28BE;
      17:      return 32'h0000_145F;
      18:      return 32'h0000_0A2F;
      19:      return 32'h0000_0517;
      20:      return 32'h0000_028B;
      21:      return 32'h0000_0145;
      22:      return 32'h0000_00A2;
      23:      return 32'h0000_0051;
      default: return '0;
    endcase
  endfunction

endpackage

### design/c2p_front.sv
// Front end: offset from the reference point, magnitudes, squares, radicand.
// Three pipeline stages; uses c2p_pkg.
module c2p_front import c2p_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [COORD_W-1:0] ref_x,
  input  logic [COORD_W-1:0] ref_y,
  input  logic               v_in,
  input  in_word_t           w_in,
  output logic               v_out,
  output cell_t              d_out
);

  logic signed [COORD_W:0] dx, dy, adx, ady;

  logic               s1_v_r;
  logic [COORD_W-1:0] s1_a_r, s1_b_r;
  flags_t             s1_f_r;

  logic                 s2_v_r;
  logic [COORD_W-1:0]   s2_a_r, s2_b_r;
  logic [2*COORD_W-1:0] s2_asq_r, s2_bsq_r;
  flags_t               s2_f_r;

  logic [SQ_W-1:0] sum;
  logic            s3_v_r;
  cell_t           s3_r, s3_nxt;

  always_comb begin
    dx  = $signed({1'b0, w_in.x_coord}) - $signed({1'b0, ref_x});
    dy  = $signed({1'b0, w_in.y_coord}) - $signed({1'b0, ref_y});
    adx = dx[COORD_W] ? -dx : dx;
    ady = dy[COORD_W] ? -dy : dy;
  end

  always_comb begin
    sum          = SQ_W'(s2_asq_r) + SQ_W'(s2_bsq_r);
    s3_nxt.cx    = CX_W'({s2_a_r, {GUARD_W{1'b0}}});
    s3_nxt.cy    = CX_W'({s2_b_r, {GUARD_W{1'b0}}});
    s3_nxt.cz    = '0;
    s3_nxt.rad   = RADICAND_W'({sum, {RAD_SHIFT{1'b0}}});
    s3_nxt.rem   = '0;
    s3_nxt.root  = '0;
    s3_nxt.f     = s2_f_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= v_in;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r        <= adx[COORD_W-1:0];
      s1_b_r        <= ady[COORD_W-1:0];
      s1_f_r.neg_x  <= dx[COORD_W];
      s1_f_r.neg_y  <= dy[COORD_W];
      s1_f_r.zero_x <= (dx == '0);
      s1_f_r.zero_y <= (dy == '0);
      s1_f_r.last   <= w_in.last_item;
      s2_a_r        <= s1_a_r;
      s2_b_r        <= s1_b_r;
      s2_asq_r      <= s1_a_r * s1_a_r;
      s2_bsq_r      <= s1_b_r * s1_b_r;
      s2_f_r        <= s1_f_r;
      s3_r          <= s3_nxt;
    end
  end

  assign v_out = s3_v_r;
  assign d_out = s3_r;

endmodule

### design/c2p_cell.sv
// One cell of the chain: a CORDIC vectoring iteration (when IDX < STEPS) and one square-root digit.
// Uses c2p_pkg.
module c2p_cell import c2p_pkg::*; #(
  parameter int IDX   = 0,
  parameter int STEPS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  v_in,
  input  cell_t d_in,
  output logic  v_out,
  output cell_t d_out
);

  localparam logic signed [Z_W-1:0] ATAN_Z =
    $signed({{(Z_W-TURN_W){1'b0}}, atan_turn(IDX)});

  logic signed [CX_W-1:0] x, y, xs, ys;
  logic signed [Z_W-1:0]  z;
  logic [REM_W-1:0]       rem_sh, trial;

  logic  v_r;
  cell_t d_r, d_nxt;

  always_comb begin
    d_nxt = d_in;
    x     = $signed(d_in.cx);
    y     = $signed(d_in.cy);
    z     = $signed(d_in.cz);
    xs    = x >>> IDX;
    ys    = y >>> IDX;
    if (IDX < STEPS) begin
      if (!y[CX_W-1]) begin
        d_nxt.cx = x + ys;
        d_nxt.cy = y - xs;
        d_nxt.cz = z + ATAN_Z;
      end else begin
        d_nxt.cx = x - ys;
        d_nxt.cy = y + xs;
        d_nxt.cz = z - ATAN_Z;
      end
    end
    // restoring square root, two radicand bits per cell
    rem_sh    = {d_in.rem[REM_W-3:0], d_in.rad[RADICAND_W-1 -: 2]};
    trial     = REM_W'({d_in.root, 2'b01});
    d_nxt.rad = {d_in.rad[RADICAND_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      d_nxt.rem  = rem_sh - trial;
      d_nxt.root = {d_in.root[RAD_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem_sh;
      d_nxt.root = {d_in.root[RAD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign v_out = v_r;
  assign d_out = d_r;

endmodule

### design/c2p_out.sv
// Back end: quadrant mapping, angle rounding, output register and skid word.
// Uses c2p_pkg and the assertion macros.
`include "cartesian_to_polar_relative_macros.svh"

module c2p_out import c2p_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      v_in,
  input  cell_t     d_in,
  output logic      adv,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam logic signed [Z_W-1:0] QUARTER_Z = $signed(Z_W'(QUARTER_TURN));

  logic signed [Z_W-1:0] z;
  logic [TURN_W-1:0]     q, full, rnd;
  logic                  org;

  logic              fin_v_r;
  logic [TURN_W-1:0] fin_full_r;
  logic [RAD_W-1:0]  fin_rad_r;
  logic              fin_org_r, fin_last_r;

  out_word_t p;
  logic      take;
  logic      out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  out_word_t out_r, out_nxt, skid_r, skid_nxt;

  always_comb begin
    z   = $signed(d_in.cz);
    org = d_in.f.zero_x && d_in.f.zero_y;
    if (z[Z_W-1]) begin
      q = '0;
    end else if (z > QUARTER_Z) begin
      q = QUARTER_TURN;
    end else begin
      q = z[TURN_W-1:0];
    end
    if (org) begin
      full = '0;
    end else if (d_in.f.zero_y) begin
      full = d_in.f.neg_x ? HALF_TURN : '0;
    end else if (d_in.f.zero_x) begin
      full = d_in.f.neg_y ? THREE_Q_TURN : QUARTER_TURN;
    end else if (!d_in.f.neg_x && !d_in.f.neg_y) begin
      full = q;
    end else if (d_in.f.neg_x && !d_in.f.neg_y) begin
      full = HALF_TURN - q;
    end else if (d_in.f.neg_x) begin
      full = HALF_TURN + q;
    end else begin
      full = '0 - q;
    end
  end

  always_comb begin
    rnd         = fin_full_r + ROUND_HALF;
    p.radius    = fin_rad_r;
    p.angle     = rnd[TURN_W-1 -: ANG_W];
    p.at_origin = fin_org_r;
    p.last_out  = fin_last_r;
  end

  always_comb begin
    take       = out_v_r && !out_stall;
    out_v_nxt  = out_v_r && !take;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (take || !out_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (!out_v_r || take) begin
      out_v_nxt = fin_v_r;
      out_nxt   = p;
    end else if (fin_v_r) begin
      out_v_nxt  = 1'b1;
      skid_v_nxt = 1'b1;
      skid_nxt   = p;
    end
  end

  assign adv = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (adv) begin
        fin_v_r <= v_in;
      end
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_full_r <= full;
      fin_rad_r  <= d_in.root;
      fin_org_r  <= org;
      fin_last_r <= d_in.f.last;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `C2P_ASSERT_IMPL(a_skid_behind_out, skid_v_r, out_v_r, "skid word without output word")
  `C2P_ASSERT_IMPL(a_origin_zero, out_v_r && out_r.at_origin, out_r.angle == '0 && out_r.radius == '0, "origin word with nonzero angle or radius")
  `C2P_ASSERT_NEXT(a_skid_holds, skid_v_r && out_stall, skid_v_r && $stable(skid_r), "skid word lost under stall")
  `C2P_ASSERT_NEXT(a_skid_fills, !skid_v_r && fin_v_r && out_v_r && out_stall, skid_v_r, "finished word dropped under stall")

endmodule

### design/cartesian_to_polar_relative.sv
// Relative Cartesian-to-polar converter: depot offset, radius and full-turn angle.
// Throughput one word per cycle while in_stall is low.
// The chain has 25 cells, each one root digit plus, in the first CORDIC_STEPS cells, one CORDIC iteration.
// A one-word skid after the output register decouples in_stall from out_stall.
// Reset (rst_n, synchronous, active low) clears all valid bits and ref_x, ref_y.
// Uses c2p_pkg, c2p_front, c2p_cell and c2p_out.
module cartesian_to_polar_relative import c2p_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COORD_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data
);

  logic [COORD_W-1:0] ref_x_r, ref_y_r;
  logic               adv;
  logic               cv [NCELLS+1];
  cell_t              cd [NCELLS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= '0;
      ref_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_REF_X: ref_x_r <= cfg_wdata;
        REG_REF_Y: ref_y_r <= cfg_wdata;
      endcase
    end
  end

  c2p_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .ref_x (ref_x_r),
    .ref_y (ref_y_r),
    .v_in  (in_valid),
    .w_in  (in_data),
    .v_out (cv[0]),
    .d_out (cd[0])
  );

  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    c2p_cell #(
      .IDX   (g),
      .STEPS (CORDIC_STEPS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .v_in  (cv[g]),
      .d_in  (cd[g]),
      .v_out (cv[g+1]),
      .d_out (cd[g+1])
    );
  end

  c2p_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .v_in      (cv[NCELLS]),
    .d_in      (cd[NCELLS]),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = !adv;

endmodule
